### hw/rtl/pal_pkg.sv
// pal_pkg: item types, operation codes and status codes of the positional array list.
// No dependencies. Used by pal_ctrl, positional_array_list and pal_checker.
package pal_pkg;

    // operation codes
    localparam logic [2:0] OP_READ    = 3'd0;
    localparam logic [2:0] OP_INSERT  = 3'd1;
    localparam logic [2:0] OP_DELETE  = 3'd2;
    localparam logic [2:0] OP_REPLACE = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // input item
    typedef struct packed {
        logic [2:0]         op;
        logic [6:0]         position;
        logic signed [31:0] new_value;
    } pal_in_t;

    // result item
    typedef struct packed {
        logic signed [31:0] old_value;
        logic [6:0]         count;
        logic [1:0]         status;
    } pal_out_t;

endpackage

### hw/rtl/pal_ram.sv
// pal_ram: generic single-clock RAM, one write port, one read port, registered read.
// No dependencies.
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/pal_ctrl.sv
// pal_ctrl: operation sequencer; checks indexes, walks the element memory for
// shifts and builds each result. Depends on pal_pkg; drives one pal_ram port pair.
module pal_ctrl #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  pal_pkg::pal_in_t            s_item,
    // result hand-off to the output register
    input  logic                        out_free,
    output logic                        res_valid,
    output pal_pkg::pal_out_t           res,
    // element memory
    output logic                        wr_en,
    output logic [$clog2(CAPACITY)-1:0] wr_addr,
    output logic [DATA_WIDTH-1:0]       wr_data,
    output logic [$clog2(CAPACITY)-1:0] rd_addr,
    input  logic [DATA_WIDTH-1:0]       rd_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int PW = (IW > 7) ? IW : 7;

    // sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_READ      = 3'd1;
    localparam logic [2:0] S_REPL      = 3'd2;
    localparam logic [2:0] S_DEL_FIRST = 3'd3;
    localparam logic [2:0] S_DEL_SHIFT = 3'd4;
    localparam logic [2:0] S_INS_SHIFT = 3'd5;
    localparam logic [2:0] S_INS_LAST  = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [IW-1:0]         used_reg,  used_next;
    logic [PW-1:0]         pos_reg,   pos_next;
    logic [AW-1:0]         ptr_reg,   ptr_next;
    logic [DATA_WIDTH-1:0] val_reg,   val_next;
    logic [31:0]           old_reg,   old_next;

    logic [PW-1:0]         pos_in;
    logic [PW-1:0]         used_w;
    logic [DATA_WIDTH-1:0] val_in;
    logic [31:0]           old_ext;
    logic [IW-1:0]         ptr_inc, ptr_inc2;
    logic [AW-1:0]         ptr_dec;
    logic [PW-1:0]         pos_inc;

    // widened views of the operands
    assign pos_in   = PW'(s_item.position);
    assign used_w   = PW'(used_reg);
    assign val_in   = DATA_WIDTH'(64'(s_item.new_value));
    assign old_ext  = 32'(64'($signed(rd_data)));
    assign ptr_inc  = IW'(ptr_reg) + IW'(1);
    assign ptr_inc2 = ptr_inc + IW'(1);
    assign ptr_dec  = ptr_reg - AW'(1);
    assign pos_inc  = pos_reg + PW'(1);

    assign s_ready = (state_reg == S_IDLE) && out_free;

    // next state, memory accesses and result
    always_comb begin
        state_next    = state_reg;
        used_next     = used_reg;
        pos_next      = pos_reg;
        ptr_next      = ptr_reg;
        val_next      = val_reg;
        old_next      = old_reg;
        wr_en         = 1'b0;
        wr_addr       = ptr_reg;
        wr_data       = rd_data;
        rd_addr       = '0;
        res_valid     = 1'b0;
        res.old_value = '0;
        res.status    = pal_pkg::STAT_OK;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && out_free) begin
                    pos_next = pos_in;
                    val_next = val_in;
                    unique case (s_item.op)
                        pal_pkg::OP_READ: begin
                            if (pos_in < used_w) begin
                                rd_addr    = AW'(pos_in);
                                state_next = S_READ;
                            end else begin
                                res_valid  = 1'b1;
                                res.status = pal_pkg::STAT_RANGE;
                            end
                        end
                        pal_pkg::OP_INSERT: begin
                            if (pos_in > used_w) begin
                                res_valid  = 1'b1;
                                res.status = pal_pkg::STAT_RANGE;
                            end else if (used_w >= PW'(CAPACITY)) begin
                                res_valid  = 1'b1;
                                res.status = pal_pkg::STAT_FULL;
                            end else if (pos_in == used_w) begin
                                // append at the tail, no shift
                                wr_en     = 1'b1;
                                wr_addr   = AW'(pos_in);
                                wr_data   = val_in;
                                used_next = used_reg + IW'(1);
                                res_valid = 1'b1;
                            end else begin
                                ptr_next   = AW'(used_reg);
                                rd_addr    = AW'(used_reg - IW'(1));
                                state_next = S_INS_SHIFT;
                            end
                        end
                        pal_pkg::OP_DELETE: begin
                            if (pos_in < used_w) begin
                                rd_addr    = AW'(pos_in);
                                ptr_next   = AW'(pos_in);
                                state_next = S_DEL_FIRST;
                            end else begin
                                res_valid  = 1'b1;
                                res.status = pal_pkg::STAT_RANGE;
                            end
                        end
                        pal_pkg::OP_REPLACE: begin
                            if (pos_in < used_w) begin
                                rd_addr    = AW'(pos_in);
                                state_next = S_REPL;
                            end else begin
                                res_valid  = 1'b1;
                                res.status = pal_pkg::STAT_RANGE;
                            end
                        end
                        pal_pkg::OP_CLEAR: begin
                            used_next = '0;
                            res_valid = 1'b1;
                        end
                        default: begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end

            S_READ: begin
                res_valid     = 1'b1;
                res.old_value = old_ext;
                state_next    = S_IDLE;
            end

            // old element arrives; overwrite in place
            S_REPL: begin
                wr_en         = 1'b1;
                wr_addr       = AW'(pos_reg);
                wr_data       = val_reg;
                res_valid     = 1'b1;
                res.old_value = old_ext;
                state_next    = S_IDLE;
            end

            S_DEL_FIRST: begin
                old_next = old_ext;
                if (pos_inc < used_w) begin
                    rd_addr    = AW'(pos_inc);
                    state_next = S_DEL_SHIFT;
                end else begin
                    used_next     = used_reg - IW'(1);
                    res_valid     = 1'b1;
                    res.old_value = old_ext;
                    state_next    = S_IDLE;
                end
            end

            // move element ptr+1 down to ptr, one per cycle
            S_DEL_SHIFT: begin
                wr_en    = 1'b1;
                ptr_next = AW'(ptr_inc);
                if (ptr_inc2 < used_reg) begin
                    rd_addr = AW'(ptr_inc2);
                end else begin
                    used_next     = used_reg - IW'(1);
                    res_valid     = 1'b1;
                    res.old_value = old_reg;
                    state_next    = S_IDLE;
                end
            end

            // move element ptr-1 up to ptr, from the tail toward the position
            S_INS_SHIFT: begin
                wr_en    = 1'b1;
                ptr_next = ptr_dec;
                if (PW'(ptr_dec) > pos_reg) begin
                    rd_addr = ptr_dec - AW'(1);
                end else begin
                    state_next = S_INS_LAST;
                end
            end

            S_INS_LAST: begin
                wr_en      = 1'b1;
                wr_addr    = AW'(pos_reg);
                wr_data    = val_reg;
                used_next  = used_reg + IW'(1);
                res_valid  = 1'b1;
                state_next = S_IDLE;
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        res.count = 7'(used_next);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
        end
    end

    // operands and walk pointer
    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        ptr_reg <= ptr_next;
        val_reg <= val_next;
        old_reg <= old_next;
    end

endmodule

### hw/rtl/positional_array_list.sv
// Accept to result valid: errors, clear, unused codes and append at the tail answer from the
// accepting state; read and replace go through one memory read; delete reads the element, then
// shifts the rest down; insert before an element shifts up from the tail, then writes the new
// one. One memory write per cycle sets the shift time. Throughput: one item at a time; the next
// is taken once the result register is free. Reset (aresetn, synchronous): count 0, result
// register empty; no memory clearing pass. Depends on pal_pkg, pal_ctrl, pal_ram.
module positional_array_list #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pal_pkg::pal_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output pal_pkg::pal_out_t m_item
);

    localparam int AW = $clog2(CAPACITY);

    logic                  out_free;
    logic                  res_valid;
    pal_pkg::pal_out_t     res;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    logic                  m_valid_reg, m_valid_next;
    pal_pkg::pal_out_t     m_item_reg,  m_item_next;

    pal_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    pal_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result register
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_item_next  = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### hw/rtl/pal_checker.sv
// pal_checker: port-level assertions for positional_array_list, with its bind.
// Depends on pal_pkg.
module pal_checker #(
    parameter int CAPACITY = 64
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input pal_pkg::pal_in_t  s_item,
    input logic              m_valid,
    input logic              m_ready,
    input pal_pkg::pal_out_t m_item
);

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // errors carry no element
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status != pal_pkg::STAT_OK |-> m_item.old_value == 32'sd0)
        else $error("error item with nonzero old_value");

    // full only when the list holds CAPACITY items
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status == pal_pkg::STAT_FULL |-> m_item.count == 7'(CAPACITY))
        else $error("full status with wrong count");

    // a clear always reports an empty list
    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.op == pal_pkg::OP_CLEAR |=> m_valid && m_item.count == 7'd0)
        else $error("clear did not report zero count");

endmodule

bind positional_array_list pal_checker #(
    .CAPACITY (CAPACITY)
) u_pal_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

### tb/positional_array_list_tb.sv
// positional_array_list_tb: self-checking bench for the positional array list.
// It keeps a shadow copy of the list that predicts every reply, and drives random traffic.
// Depends on pal_pkg and positional_array_list.
module positional_array_list_tb;

    localparam int LIST_DEPTH     = 64;
    localparam int RANDOM_ITEMS   = 740;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 80;
    localparam int GAP_PERCENT    = 16;

    // op codes the block treats as no-ops
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam logic [6:0] POS_TOP        = 7'd127;

    typedef enum {MIX_GROW, MIX_SHRINK, MIX_BALANCED} traffic_mix_t;

    // one predicted reply and the item that caused it
    typedef struct {
        pal_pkg::pal_in_t  cause;
        pal_pkg::pal_out_t reply;
    } reply_due_t;

    // shadow of the list contents; predicts replies and checks them in order
    class list_shadow;
        logic signed [31:0] cells [LIST_DEPTH];
        int unsigned        used;
        reply_due_t         replies_due [$];
        int                 failures;
        int                 replies_seen;
        int                 op_hits [8];
        int                 range_hits;
        int                 full_hits;
        int                 peak_used;

        function new();
            used         = 0;
            failures     = 0;
            replies_seen = 0;
            range_hits   = 0;
            full_hits    = 0;
            peak_used    = 0;
            foreach (op_hits[i]) op_hits[i] = 0;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        // work out the reply to an accepted item and update the shadow list
        function void apply_op(pal_pkg::pal_in_t it);
            reply_due_t  due;
            int unsigned pos;
            int unsigned p;
            pos        = it.position;
            due.cause  = it;
            due.reply  = '0;
            case (it.op)
                pal_pkg::OP_READ: begin
                    if (pos < used) due.reply.old_value = cells[pos];
                    else due.reply.status = pal_pkg::STAT_RANGE;
                end
                pal_pkg::OP_INSERT: begin
                    if (pos > used) begin
                        due.reply.status = pal_pkg::STAT_RANGE;
                    end else if (used >= LIST_DEPTH) begin
                        due.reply.status = pal_pkg::STAT_FULL;
                    end else begin
                        for (p = used; p > pos; p--) cells[p] = cells[p - 1];
                        cells[pos] = it.new_value;
                        used++;
                    end
                end
                pal_pkg::OP_DELETE: begin
                    if (pos < used) begin
                        due.reply.old_value = cells[pos];
                        for (p = pos; p + 1 < used; p++) cells[p] = cells[p + 1];
                        used--;
                    end else begin
                        due.reply.status = pal_pkg::STAT_RANGE;
                    end
                end
                pal_pkg::OP_REPLACE: begin
                    if (pos < used) begin
                        due.reply.old_value = cells[pos];
                        cells[pos] = it.new_value;
                    end else begin
                        due.reply.status = pal_pkg::STAT_RANGE;
                    end
                end
                pal_pkg::OP_CLEAR: begin
                    used = 0;
                end
                default: ;
            endcase
            due.reply.count = used[6:0];
            op_hits[it.op]++;
            if (due.reply.status == pal_pkg::STAT_RANGE) range_hits++;
            if (due.reply.status == pal_pkg::STAT_FULL) full_hits++;
            if (used > peak_used) peak_used = used;
            replies_due.push_back(due);
        endfunction

        function void report_fault(string msg);
            failures++;
            if (failures <= 10) $display("[%0t] %s", $realtime, msg);
        endfunction

        // compare one accepted reply against the oldest prediction
        function void check_reply(pal_pkg::pal_out_t got);
            reply_due_t due;
            replies_seen++;
            if (replies_due.size() == 0) begin
                report_fault($sformatf("unexpected reply old=%0d count=%0d status=%0d",
                    got.old_value, got.count, got.status));
                return;
            end
            due = replies_due.pop_front();
            if (got.old_value !== due.reply.old_value || got.count !== due.reply.count ||
                got.status !== due.reply.status) begin
                report_fault($sformatf({"op=%0d pos=%0d: expected old=%0d count=%0d status=%0d,",
                    " got old=%0d count=%0d status=%0d"},
                    due.cause.op, due.cause.position, due.reply.old_value, due.reply.count,
                    due.reply.status, got.old_value, got.count, got.status));
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    pal_pkg::pal_in_t  s_item;
    logic              m_valid;
    logic              m_ready;
    pal_pkg::pal_out_t m_item;

    list_shadow shadow;
    bit         gaps_on;
    int         idle_cycles;
    int         items_sent;

    positional_array_list #(
        .CAPACITY   (LIST_DEPTH),
        .DATA_WIDTH (32)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // clock
    always #6 aclk = ~aclk;

    // receiver back-pressure, changed on the falling edge
    always @(negedge aclk) begin
        m_ready <= !gaps_on || ($urandom_range(99) >= GAP_PERCENT);
    end

    // monitor both channels; watchdog on cycles with no traffic
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) shadow.apply_op(s_item);
            if (m_valid && m_ready) shadow.check_reply(m_item);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("** positional_array_list: FAILED **");
                $finish;
            end
        end
    end

    // a value with the extremes weighted in
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(19))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // drive one item; called and returns on a falling edge
    task automatic push_op(input logic [2:0] op, input logic [6:0] pos,
                           input logic signed [31:0] val);
        pal_pkg::pal_in_t it;
        it.op        = op;
        it.position  = pos;
        it.new_value = val;
        while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    // hold off the sender until every reply has come back
    task automatic wait_list_quiet();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (shadow.pending() != 0) @(negedge aclk);
    endtask

    // one random item shaped by the current mix
    task automatic push_random(input traffic_mix_t mix);
        int            r;
        int            ins_cut;
        int            del_cut;
        logic [2:0]    op;
        logic [6:0]    pos;
        int unsigned   len;
        len     = shadow.used;
        r       = $urandom_range(99);
        ins_cut = (mix == MIX_GROW) ? 62 : (mix == MIX_SHRINK) ? 12 : 32;
        del_cut = (mix == MIX_SHRINK) ? 74 : ins_cut + 22;
        if (r < 2)            op = pal_pkg::OP_CLEAR;
        else if (r < 4)       op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        else if (r < ins_cut) op = pal_pkg::OP_INSERT;
        else if (r < del_cut) op = pal_pkg::OP_DELETE;
        else if (r < 88)      op = pal_pkg::OP_READ;
        else                  op = pal_pkg::OP_REPLACE;
        r = $urandom_range(99);
        if (r < 12)                        pos = 7'($urandom_range(POS_TOP));
        else if (r < 18)                   pos = 7'(len);
        else if (op == pal_pkg::OP_INSERT) pos = 7'($urandom_range(len));
        else if (len == 0)                 pos = 7'd0;
        else                               pos = 7'($urandom_range(len - 1));
        push_op(op, pos, pick_word());
    endtask

    // stimulus and end of run
    initial begin
        traffic_mix_t mix;
        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_item      = '0;
        m_ready     = 1'b0;
        gaps_on     = 1'b1;
        idle_cycles = 0;
        items_sent  = 0;
        shadow      = new();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty-list errors, ends of the list, extremes, spare codes, clear
        push_op(pal_pkg::OP_READ,    7'd0,    32'sd5);
        push_op(pal_pkg::OP_DELETE,  7'd0,    32'sd0);
        push_op(pal_pkg::OP_REPLACE, 7'd0,    32'sd9);
        push_op(pal_pkg::OP_INSERT,  7'd1,    32'sd1);
        push_op(pal_pkg::OP_INSERT,  7'd0,    32'sh7FFF_FFFF);
        push_op(pal_pkg::OP_INSERT,  7'd0,    32'sh8000_0000);
        push_op(pal_pkg::OP_INSERT,  7'd2,    32'sd0);
        push_op(pal_pkg::OP_INSERT,  7'd1,    -32'sd1);
        push_op(pal_pkg::OP_READ,    7'd0,    32'sd0);
        push_op(pal_pkg::OP_READ,    7'd3,    32'sd0);
        push_op(pal_pkg::OP_READ,    7'd4,    32'sd0);
        push_op(pal_pkg::OP_REPLACE, 7'd3,    32'sh5555_5555);
        push_op(pal_pkg::OP_REPLACE, 7'd0,    32'shAAAA_AAAA);
        push_op(pal_pkg::OP_DELETE,  7'd1,    32'sd0);
        push_op(pal_pkg::OP_READ,    POS_TOP, 32'sd0);
        push_op(pal_pkg::OP_INSERT,  POS_TOP, 32'sd3);
        push_op(OP_SPARE_FIRST, 7'd0, 32'sd7);
        push_op(OP_SPARE_LAST, POS_TOP, -32'sd1);
        push_op(pal_pkg::OP_DELETE,  7'd2,    32'sd0);
        push_op(pal_pkg::OP_DELETE,  7'd0,    32'sd0);
        push_op(pal_pkg::OP_CLEAR,   7'd5,    32'sd0);
        push_op(pal_pkg::OP_READ,    7'd0,    32'sd0);
        wait_list_quiet();

        // fill to capacity, then hit the full and range checks at the top
        while (shadow.used < LIST_DEPTH)
            push_op(pal_pkg::OP_INSERT, 7'($urandom_range(shadow.used)), pick_word());
        push_op(pal_pkg::OP_INSERT,  7'(LIST_DEPTH),     32'sd1);
        push_op(pal_pkg::OP_INSERT,  7'd0,               32'sd2);
        push_op(pal_pkg::OP_INSERT,  7'(LIST_DEPTH + 1), 32'sd3);
        push_op(pal_pkg::OP_READ,    7'(LIST_DEPTH - 1), 32'sd0);
        push_op(pal_pkg::OP_READ,    7'(LIST_DEPTH),     32'sd0);
        push_op(pal_pkg::OP_DELETE,  7'(LIST_DEPTH - 1), 32'sd0);
        push_op(pal_pkg::OP_DELETE,  7'd0,               32'sd0);

        // random traffic in phases of growing, shrinking and mixed use
        mix = MIX_GROW;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 40 == 0) mix = traffic_mix_t'($urandom_range(2));
            if (k == 250) gaps_on = 1'b0;
            if (k == 450) gaps_on = 1'b1;
            if (k == 500) wait_list_quiet();
            push_random(mix);
        end

        wait_list_quiet();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run: %0d items (%0d read, %0d insert, %0d delete, %0d replace, %0d clear)",
            items_sent, shadow.op_hits[pal_pkg::OP_READ],
            shadow.op_hits[pal_pkg::OP_INSERT], shadow.op_hits[pal_pkg::OP_DELETE],
            shadow.op_hits[pal_pkg::OP_REPLACE], shadow.op_hits[pal_pkg::OP_CLEAR]);
        $display("run: %0d replies, %0d range errors, %0d full-list rejects, peak length %0d",
            shadow.replies_seen, shadow.range_hits, shadow.full_hits, shadow.peak_used);
        if (shadow.failures == 0 && shadow.pending() == 0) begin
            $display("** positional_array_list: PASSED **");
        end else begin
            $display("%0d failures, %0d replies missing", shadow.failures, shadow.pending());
            $display("** positional_array_list: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/pal_pkg.sv
hw/rtl/pal_ram.sv
hw/rtl/pal_ctrl.sv
hw/rtl/positional_array_list.sv
hw/rtl/pal_checker.sv
tb/positional_array_list_tb.sv
